// ===== design/e2q_pkg.sv =====
// Shared types, constants and constant functions for the Euler-to-quaternion block.
package e2q_pkg;

    localparam int E2Q_CORDIC_STEPS = 16;
    localparam int ANGLE_W = 16;
    localparam int QUAT_W = 16;
    localparam int DATA_W = 32;

    localparam logic signed [DATA_W-1:0] ANG_PI      = 32'sd843314857;
    localparam logic signed [DATA_W-1:0] ANG_HALF_PI = 32'sd421657428;
    localparam logic signed [17:0]       Q_ONE       = 18'sd16384;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
        logic                     flip;
    } rot_t;

    // atan(2^-i), 28 fraction bits
    function automatic logic signed [DATA_W-1:0] atan_value(input int i);
        logic signed [DATA_W-1:0] v;
        unique case (i)
            0:  v = 32'sd210828714;
            1:  v = 32'sd124459457;
            2:  v = 32'sd65760959;
            3:  v = 32'sd33381290;
            4:  v = 32'sd16755422;
            5:  v = 32'sd8385879;
            6:  v = 32'sd4193963;
            7:  v = 32'sd2097109;
            8:  v = 32'sd1048571;
            9:  v = 32'sd524287;
            10: v = 32'sd262144;
            11: v = 32'sd131072;
            12: v = 32'sd65536;
            13: v = 32'sd32768;
            14: v = 32'sd16384;
            15: v = 32'sd8192;
            16: v = 32'sd4096;
            17: v = 32'sd2048;
            18: v = 32'sd1024;
            19: v = 32'sd512;
            20: v = 32'sd256;
            21: v = 32'sd128;
            22: v = 32'sd64;
            23: v = 32'sd32;
            default: v = '0;
        endcase
        return v;
    endfunction

    // squared gain, 60 fraction bits
    function automatic logic [63:0] gain_sq(input int n);
        logic [63:0] p;
        p = 64'd1 << 60;
        for (int i = 0; i < n; i++)
            p = p + (p >> (2 * i));
        return p;
    endfunction

    function automatic logic [63:0] isqrt_u64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bitv;
        v = v_in;
        res = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (res == 64'd0)
            res = 64'd1;
        return res;
    endfunction

    // floor(a*b / 2^30)
    function automatic logic signed [DATA_W-1:0] mul30(input logic signed [DATA_W-1:0] a,
                                                       input logic signed [DATA_W-1:0] b);
        logic signed [2*DATA_W-1:0] p;
        p = a * b;
        return p[61:30];
    endfunction

endpackage

// ===== design/euler_to_quaternion.sv =====
// Euler angles (ZYX) to unit quaternion: CORDIC cell row and product pipeline.
//  channel | signals                                   | handshake
//  input   | start, roll_angle, pitch_angle, yaw_angle | beat taken when start & !busy
//  result  | done, quat_w, quat_x, quat_y, quat_z      | one-cycle strobe on done
// One beat per cycle; busy stays low. The path runs through the
// input fold register, one cell per CORDIC step, sign fix, two multiply
// stages and the rounding register. Reset clears only the valid chain.
// The receiver cannot stall; every result shows for exactly one cycle.
module euler_to_quaternion #(
    parameter int CORDIC_STEPS = e2q_pkg::E2Q_CORDIC_STEPS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] roll_angle,
    input  logic [15:0] pitch_angle,
    input  logic [15:0] yaw_angle,
    output logic        done,
    output logic [15:0] quat_w,
    output logic [15:0] quat_x,
    output logic [15:0] quat_y,
    output logic [15:0] quat_z
);
    import e2q_pkg::*;

    localparam logic [63:0] GAIN_K = (64'd1 << 60) / isqrt_u64(gain_sq(CORDIC_STEPS));

    logic             valid_chain [CORDIC_STEPS+1];
    rot_t [2:0]       rot_chain [CORDIC_STEPS+1];
    rot_t [2:0]       rot_in_next;
    logic             in_valid_reg;
    rot_t [2:0]       rot_in_reg;
    logic             cs_valid_reg;
    logic [2:0][31:0] cos_reg, sin_reg;
    logic [3:0][15:0] quat;
    logic [15:0]      angles [3];

    assign busy = 1'b0;
    assign angles[0] = roll_angle;
    assign angles[1] = pitch_angle;
    assign angles[2] = yaw_angle;

    // half angle in 28 fraction bits, folded into +-pi/2
    always_comb
    begin
        logic signed [DATA_W-1:0] z;
        for (int a = 0; a < 3; a++) begin
            z = {{2{angles[a][15]}}, angles[a], 14'b0};
            rot_in_next[a].x = signed'(GAIN_K[DATA_W-1:0]);
            rot_in_next[a].y = '0;
            rot_in_next[a].flip = 1'b0;
            if (z > ANG_HALF_PI) begin
                z = z - ANG_PI;
                rot_in_next[a].flip = 1'b1;
            end
            else if (z < -ANG_HALF_PI) begin
                z = z + ANG_PI;
                rot_in_next[a].flip = 1'b1;
            end
            rot_in_next[a].z = z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            cs_valid_reg <= 1'b0;
        end
        else begin
            in_valid_reg <= start & ~busy;
            cs_valid_reg <= valid_chain[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        rot_in_reg <= rot_in_next;
        for (int a = 0; a < 3; a++) begin
            cos_reg[a] <= rot_chain[CORDIC_STEPS][a].flip ? -rot_chain[CORDIC_STEPS][a].x
                                                          : rot_chain[CORDIC_STEPS][a].x;
            sin_reg[a] <= rot_chain[CORDIC_STEPS][a].flip ? -rot_chain[CORDIC_STEPS][a].y
                                                          : rot_chain[CORDIC_STEPS][a].y;
        end
    end

    assign valid_chain[0] = in_valid_reg;
    assign rot_chain[0]   = rot_in_reg;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        e2q_cordic_cell #(
            .STAGE (g)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (valid_chain[g]),
            .rot_in    (rot_chain[g]),
            .valid_out (valid_chain[g+1]),
            .rot_out   (rot_chain[g+1])
        );
    end

    e2q_quat_mix u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cs_valid_reg),
        .cos_in    (cos_reg),
        .sin_in    (sin_reg),
        .valid_out (done),
        .quat_out  (quat)
    );

    assign quat_w = quat[0];
    assign quat_x = quat[1];
    assign quat_y = quat[2];
    assign quat_z = quat[3];
endmodule

// ===== design/e2q_cordic_cell.sv =====
// One CORDIC rotation step for the three half angles.
module e2q_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid_in,
    input  e2q_pkg::rot_t [2:0]  rot_in,
    output logic                 valid_out,
    output e2q_pkg::rot_t [2:0]  rot_out
);
    import e2q_pkg::*;

    localparam logic signed [DATA_W-1:0] ATAN = atan_value(STAGE);

    logic          valid_reg;
    rot_t [2:0]    rot_reg;
    rot_t [2:0]    rot_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++) begin
            rot_next[a].flip = rot_in[a].flip;
            if (rot_in[a].z >= 0) begin
                rot_next[a].x = rot_in[a].x - (rot_in[a].y >>> STAGE);
                rot_next[a].y = rot_in[a].y + (rot_in[a].x >>> STAGE);
                rot_next[a].z = rot_in[a].z - ATAN;
            end
            else begin
                rot_next[a].x = rot_in[a].x + (rot_in[a].y >>> STAGE);
                rot_next[a].y = rot_in[a].y - (rot_in[a].x >>> STAGE);
                rot_next[a].z = rot_in[a].z + ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        rot_reg <= rot_next;
    end

    assign valid_out = valid_reg;
    assign rot_out   = rot_reg;
endmodule

// ===== design/e2q_quat_mix.sv =====
// Triple products, sums, rounding and saturation into Q1.14.
module e2q_quat_mix (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    input  logic [2:0][31:0] cos_in,
    input  logic [2:0][31:0] sin_in,
    output logic        valid_out,
    output logic [3:0][15:0] quat_out
);
    import e2q_pkg::*;

    logic signed [DATA_W-1:0] cr, sr, cp, sp, cy, sy;
    logic                     v1_reg, v2_reg, v3_reg;
    logic signed [DATA_W-1:0] pair_reg [4];
    logic signed [DATA_W-1:0] tri_reg [8];
    logic [3:0][15:0]         quat_reg;
    logic [3:0][15:0]         quat_next;

    assign cr = signed'(cos_in[0]);
    assign sr = signed'(sin_in[0]);
    assign cp = signed'(cos_in[1]);
    assign sp = signed'(sin_in[1]);
    assign cy = signed'(cos_in[2]);
    assign sy = signed'(sin_in[2]);

    // beat carries cy/sy along with the pair products
    logic signed [DATA_W-1:0] cy_reg, sy_reg;

    always_ff @(posedge clk)
    begin
        pair_reg[0] <= mul30(cr, cp);
        pair_reg[1] <= mul30(sr, sp);
        pair_reg[2] <= mul30(sr, cp);
        pair_reg[3] <= mul30(cr, sp);
        cy_reg      <= cy;
        sy_reg      <= sy;
        tri_reg[0]  <= mul30(pair_reg[0], cy_reg);
        tri_reg[1]  <= mul30(pair_reg[1], sy_reg);
        tri_reg[2]  <= mul30(pair_reg[2], cy_reg);
        tri_reg[3]  <= mul30(pair_reg[3], sy_reg);
        tri_reg[4]  <= mul30(pair_reg[3], cy_reg);
        tri_reg[5]  <= mul30(pair_reg[2], sy_reg);
        tri_reg[6]  <= mul30(pair_reg[0], sy_reg);
        tri_reg[7]  <= mul30(pair_reg[1], cy_reg);
        quat_reg    <= quat_next;
    end

    always_comb
    begin
        logic signed [DATA_W+1:0] s;
        logic signed [17:0]       r;
        for (int q = 0; q < 4; q++) begin
            if (q == 1 || q == 3)
                s = 34'(tri_reg[2*q]) - 34'(tri_reg[2*q+1]);
            else
                s = 34'(tri_reg[2*q]) + 34'(tri_reg[2*q+1]);
            s = s + 34'sd32768;
            r = 18'(s >>> 16);
            if (r > Q_ONE)
                r = Q_ONE;
            else if (r < -Q_ONE)
                r = -Q_ONE;
            quat_next[q] = r[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign quat_out  = quat_reg;
endmodule

// ===== tb/euler_to_quaternion_tb.sv =====
// Self-checking testbench for the Euler-angle to quaternion block.
`timescale 1ns / 100ps

module euler_to_quaternion_tb;
    import e2q_pkg::*;

    localparam int PIPE_LAT   = E2Q_CORDIC_STEPS + 5;
    localparam int N_RANDOM   = 900;
    localparam int CALM_TAIL  = 200;
    localparam int STALL_MAX  = 4000;
    localparam int N_ITER     = (E2Q_CORDIC_STEPS > 24) ? 24 : E2Q_CORDIC_STEPS;
    localparam longint ONE60  = 64'sd1 <<< 60;
    localparam longint PI28   = 64'sd843314857;
    localparam longint HPI28  = 64'sd421657428;

    // atan(2^-i) with 28 fraction bits
    localparam longint ATAN28 [24] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } quat_t;

    typedef struct {
        logic [15:0] roll;
        logic [15:0] pitch;
        logic [15:0] yaw;
        bit          typed;
        quat_t       q;
    } angle_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [15:0] roll_angle;
    logic [15:0] pitch_angle;
    logic [15:0] yaw_angle;
    logic        done;
    logic [15:0] quat_w;
    logic [15:0] quat_x;
    logic [15:0] quat_y;
    logic [15:0] quat_z;

    quat_t  quat_pending[$];
    quat_t  typed_pending[$];
    bit     typed_flag[$];
    int     n_fail;
    int     n_sent;
    int     n_got;
    int     stall_cnt;
    longint cordic_k;

    euler_to_quaternion dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .roll_angle (roll_angle),
        .pitch_angle(pitch_angle),
        .yaw_angle  (yaw_angle),
        .done       (done),
        .quat_w     (quat_w),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] b;
        rem = v;
        root = '0;
        b = 64'd1 << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= root + b)
            begin
                rem = rem - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return (root == 0) ? 1 : longint'(root);
    endfunction

    function automatic longint start_gain();
        logic [63:0] p;
        p = 64'd1 << 60;
        for (int i = 0; i < N_ITER; i++)
            p = p + (p >> (2 * i));
        return ONE60 / floor_sqrt(p);
    endfunction

    // cos and sin of half the angle, 30 fraction bits
    function automatic void half_trig(input logic [15:0] ang, output longint c,
                                      output longint s);
        longint zr;
        longint xr;
        longint yr;
        longint xn;
        bit     neg;
        zr = longint'($signed(ang)) * 16384;
        xr = cordic_k;
        yr = 0;
        neg = 1'b0;
        if (zr > HPI28)
        begin
            zr = zr - PI28;
            neg = 1'b1;
        end
        else if (zr < -HPI28)
        begin
            zr = zr + PI28;
            neg = 1'b1;
        end
        for (int i = 0; i < N_ITER; i++)
        begin
            if (zr >= 0)
            begin
                xn = xr - (yr >>> i);
                yr = yr + (xr >>> i);
                zr = zr - ATAN28[i];
            end
            else
            begin
                xn = xr + (yr >>> i);
                yr = yr - (xr >>> i);
                zr = zr + ATAN28[i];
            end
            xr = xn;
        end
        c = neg ? -xr : xr;
        s = neg ? -yr : yr;
    endfunction

    function automatic longint prod3(input longint a, input longint b, input longint c);
        longint ab;
        ab = (a * b) >>> 30;
        return (ab * c) >>> 30;
    endfunction

    function automatic logic [15:0] round_q14(input longint sum);
        longint r;
        r = (sum + 32768) >>> 16;
        if (r > 16384)
            r = 16384;
        if (r < -16384)
            r = -16384;
        return r[15:0];
    endfunction

    function automatic quat_t zyx_quat(input logic [15:0] r, input logic [15:0] p,
                                       input logic [15:0] y);
        longint cr, sr, cp, sp, cy, sy;
        quat_t  q;
        half_trig(r, cr, sr);
        half_trig(p, cp, sp);
        half_trig(y, cy, sy);
        q.w = round_q14(prod3(cr, cp, cy) + prod3(sr, sp, sy));
        q.x = round_q14(prod3(sr, cp, cy) - prod3(cr, sp, sy));
        q.y = round_q14(prod3(cr, sp, cy) + prod3(sr, cp, sy));
        q.z = round_q14(prod3(cr, cp, sy) - prod3(sr, sp, cy));
        return q;
    endfunction

    // Directed rows: a typed result is checked against the predictor as well.
    task automatic push_beat(input logic [15:0] r, input logic [15:0] p,
                             input logic [15:0] y);
        quat_pending.push_back(zyx_quat(r, p, y));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cnt <= 0;
            else
                stall_cnt <= stall_cnt + 1;
            if (start && !busy)
            begin
                push_beat(roll_angle, pitch_angle, yaw_angle);
                n_sent++;
            end
            if (done)
            begin
                quat_t exp_q;
                quat_t got_q;
                got_q = '{quat_w, quat_x, quat_y, quat_z};
                if (quat_pending.size() == 0)
                begin
                    $error("result beat with nothing expected: w=%0d x=%0d y=%0d z=%0d",
                           $signed(quat_w), $signed(quat_x), $signed(quat_y), $signed(quat_z));
                    n_fail++;
                end
                else
                begin
                    exp_q = quat_pending.pop_front();
                    if (typed_flag.size() != 0 && typed_flag.pop_front())
                    begin
                        quat_t t;
                        t = typed_pending.pop_front();
                        if (t != exp_q)
                        begin
                            $error("typed row disagrees with predictor: %h vs %h", t, exp_q);
                            n_fail++;
                        end
                        exp_q = t;
                    end
                    if (got_q.w !== exp_q.w)
                    begin
                        $error("quat_w expected %0d got %0d", $signed(exp_q.w), $signed(got_q.w));
                        n_fail++;
                    end
                    if (got_q.x !== exp_q.x)
                    begin
                        $error("quat_x expected %0d got %0d", $signed(exp_q.x), $signed(got_q.x));
                        n_fail++;
                    end
                    if (got_q.y !== exp_q.y)
                    begin
                        $error("quat_y expected %0d got %0d", $signed(exp_q.y), $signed(got_q.y));
                        n_fail++;
                    end
                    if (got_q.z !== exp_q.z)
                    begin
                        $error("quat_z expected %0d got %0d", $signed(exp_q.z), $signed(got_q.z));
                        n_fail++;
                    end
                end
                n_got++;
            end
            if (stall_cnt >= STALL_MAX)
            begin
                $display("watchdog: no beat for %0d cycles", STALL_MAX);
                $display("euler_to_quaternion_tb NOT OK");
                $finish;
            end
        end
    end

    // Drive one beat and hold it until taken; start stays high for the next beat.
    task automatic drive_beat(input logic [15:0] r, input logic [15:0] p,
                              input logic [15:0] y, input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start       <= 1'b1;
        roll_angle  <= r;
        pitch_angle <= p;
        yaw_angle   <= y;
        do @(posedge clk); while (busy);
    endtask

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(0, 4) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 2 * 25736) - 25736);
    endfunction

    angle_row_t dir_rows[$];

    initial
    begin
        logic [15:0] ra, pa, ya;
        rst_n       = 1'b0;
        start       = 1'b0;
        roll_angle  = '0;
        pitch_angle = '0;
        yaw_angle   = '0;
        n_fail      = 0;
        n_sent      = 0;
        n_got       = 0;
        stall_cnt   = 0;
        cordic_k    = start_gain();

        dir_rows = '{
            '{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0}},
            '{16'sd25736, 16'sd0, 16'sd0, 1'b0, '0},
            '{-16'sd25736, 16'sd0, 16'sd0, 1'b0, '0},
            '{16'sd0, 16'sd25736, 16'sd0, 1'b0, '0},
            '{16'sd0, -16'sd25736, 16'sd0, 1'b0, '0},
            '{16'sd0, 16'sd0, 16'sd25736, 1'b0, '0},
            '{16'sd0, 16'sd0, -16'sd25736, 1'b0, '0},
            // just past pi: the half angle folds
            '{16'sd25737, 16'sd0, 16'sd0, 1'b0, '0},
            '{16'sd0, -16'sd25737, 16'sd0, 1'b0, '0},
            '{16'sd0, 16'sd0, 16'sd25737, 1'b0, '0},
            '{16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '0},
            '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
            '{16'h7fff, 16'h8000, 16'h0000, 1'b0, '0},
            '{16'h8000, 16'h0000, 16'h7fff, 1'b0, '0},
            '{16'sd12868, 16'sd12868, 16'sd12868, 1'b0, '0},
            '{-16'sd12868, 16'sd12868, -16'sd12868, 1'b0, '0},
            '{16'sd1, -16'sd1, 16'sd1, 1'b0, '0},
            '{16'sd25736, 16'sd25736, 16'sd25736, 1'b0, '0},
            '{-16'sd25736, -16'sd25736, -16'sd25736, 1'b0, '0},
            '{16'hffff, 16'h5555, 16'haaaa, 1'b0, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            typed_flag.push_back(dir_rows[i].typed);
            if (dir_rows[i].typed)
                typed_pending.push_back(dir_rows[i].q);
            drive_beat(dir_rows[i].roll, dir_rows[i].pitch, dir_rows[i].yaw, 1'b1);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            ra = rand_angle();
            pa = rand_angle();
            ya = rand_angle();
            drive_beat(ra, pa, ya, n < N_RANDOM - CALM_TAIL);
        end
        start <= 1'b0;

        while (quat_pending.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 10) @(posedge clk);

        $display("%0d angle triples sent, %0d quaternions checked", n_sent, n_got);
        $display("directed extremes, half-angle folds and random angles over the full range");
        if (n_fail == 0)
            $display("euler_to_quaternion_tb OK");
        else
            $display("euler_to_quaternion_tb NOT OK");
        $finish;
    end

endmodule

// ===== euler_to_quaternion.f =====
design/e2q_pkg.sv
design/e2q_cordic_cell.sv
design/e2q_quat_mix.sv
design/euler_to_quaternion.sv
tb/euler_to_quaternion_tb.sv
